/* design/cpr_pkg.sv */
package cpr_pkg;

  localparam int PAGE_W     = 10;
  localparam int HIT_W      = 32;
  localparam int PAGES_DEF  = 1024;
  localparam int FRAMES_DEF = 256;

  // page table word layout
  localparam int PT_W       = 2;
  localparam int PT_PRESENT = 1;
  localparam int PT_REFD    = 0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_FETCH,
    ST_CHECK
  } cpr_state_e;

  // page number reduced modulo the page count, restoring compare/subtract
  function automatic logic [PAGE_W-1:0] page_mod(input logic [PAGE_W-1:0] p,
                                                 input int unsigned pages);
    logic [31:0] r;
    logic [31:0] m;
    r = 32'(p);
    for (int k = PAGE_W - 1; k >= 0; k--) begin
      m = 32'(pages) << k;
      if ((m < (32'd1 << PAGE_W)) && (r >= m)) begin
        r = r - m;
      end
    end
    return r[PAGE_W-1:0];
  endfunction

endpackage

/* design/clock_page_replacement_unit.sv */
// Clock (second chance) page replacement. Raise start with a page number
// while busy is low; one result word follows on done_o for exactly one
// cycle and must be captured then, since the unit cannot be stalled.
// After reset the page table is swept clear, one entry a cycle, so busy
// stays high until all PAGES entries (1024 by default) are clear, before
// the first reference is taken; cfg_we_i writes are taken at any time.
// A hit or a fill into a free frame reads the page table and writes the
// entry back before done. A miss on a full ring sweeps the hand past each
// referenced frame to the victim: each step of the sweep is a frame ring
// read followed by a page table read-modify-write.
// hit_count_o holds the saturating running hit total.
module clock_page_replacement_unit #(
  parameter int PAGES  = cpr_pkg::PAGES_DEF,
  parameter int FRAMES = cpr_pkg::FRAMES_DEF,
  localparam int AW = (PAGES > 1) ? $clog2(PAGES) : 1,
  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1,
  localparam int CW = $clog2(FRAMES + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [cpr_pkg::PAGE_W-1:0] page_i,
  input  logic                       cfg_we_i,
  input  logic [CW-1:0]              cfg_wdata_i,
  output logic                       done_o,
  output logic                       hit_o,
  output logic                       evicted_o,
  output logic [cpr_pkg::PAGE_W-1:0] evicted_page_o,
  output logic [FW-1:0]              slot_o,
  output logic [cpr_pkg::HIT_W-1:0]  hit_count_o
);
  import cpr_pkg::*;

  // frames_in_use register and its clamped ring size
  logic [CW-1:0] frames_q;
  logic [CW-1:0] ring_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= CW'(FRAMES);
    end else if (cfg_we_i) begin
      frames_q <= cfg_wdata_i;
    end
  end

  // zero acts as one frame, anything above the ring depth as the full ring
  always_comb begin
    if (frames_q == '0) begin
      ring_n = CW'(1);
    end else if (frames_q > CW'(FRAMES)) begin
      ring_n = CW'(FRAMES);
    end else begin
      ring_n = frames_q;
    end
  end

  // page table: {present, referenced} per page
  logic            pt_we;
  logic [AW-1:0]   pt_waddr;
  logic [PT_W-1:0] pt_wdata;
  logic [AW-1:0]   pt_raddr;
  logic [PT_W-1:0] pt_rdata;

  // frame ring: resident page number per frame
  logic          fm_we;
  logic [FW-1:0] fm_waddr;
  logic [AW-1:0] fm_wdata;
  logic [FW-1:0] fm_raddr;
  logic [AW-1:0] fm_rdata;

  cpr_ram #(
    .WIDTH (PT_W),
    .DEPTH (PAGES)
  ) u_page_table (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (pt_waddr),
    .wdata_i (pt_wdata),
    .raddr_i (pt_raddr),
    .rdata_o (pt_rdata)
  );

  cpr_ram #(
    .WIDTH (AW),
    .DEPTH (FRAMES)
  ) u_frame_ring (
    .clk_i   (clk_i),
    .we_i    (fm_we),
    .waddr_i (fm_waddr),
    .wdata_i (fm_wdata),
    .raddr_i (fm_raddr),
    .rdata_o (fm_rdata)
  );

  cpr_ctrl #(
    .PAGES  (PAGES),
    .FRAMES (FRAMES)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_o         (busy),
    .page_i         (page_i),
    .ring_n_i       (ring_n),
    .pt_we_o        (pt_we),
    .pt_waddr_o     (pt_waddr),
    .pt_wdata_o     (pt_wdata),
    .pt_raddr_o     (pt_raddr),
    .pt_rdata_i     (pt_rdata),
    .fm_we_o        (fm_we),
    .fm_waddr_o     (fm_waddr),
    .fm_wdata_o     (fm_wdata),
    .fm_raddr_o     (fm_raddr),
    .fm_rdata_i     (fm_rdata),
    .done_o         (done_o),
    .hit_o          (hit_o),
    .evicted_o      (evicted_o),
    .evicted_page_o (evicted_page_o),
    .slot_o         (slot_o),
    .hit_count_o    (hit_count_o)
  );

endmodule

/* design/cpr_ram.sv */
module cpr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/cpr_ctrl.sv */
module cpr_ctrl #(
  parameter int PAGES  = cpr_pkg::PAGES_DEF,
  parameter int FRAMES = cpr_pkg::FRAMES_DEF,
  localparam int AW = (PAGES > 1) ? $clog2(PAGES) : 1,
  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1,
  localparam int CW = $clog2(FRAMES + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [cpr_pkg::PAGE_W-1:0]  page_i,
  input  logic [CW-1:0]               ring_n_i,
  // page table port
  output logic                        pt_we_o,
  output logic [AW-1:0]               pt_waddr_o,
  output logic [cpr_pkg::PT_W-1:0]    pt_wdata_o,
  output logic [AW-1:0]               pt_raddr_o,
  input  logic [cpr_pkg::PT_W-1:0]    pt_rdata_i,
  // frame ring port
  output logic                        fm_we_o,
  output logic [FW-1:0]               fm_waddr_o,
  output logic [AW-1:0]               fm_wdata_o,
  output logic [FW-1:0]               fm_raddr_o,
  input  logic [AW-1:0]               fm_rdata_i,
  // result word
  output logic                        done_o,
  output logic                        hit_o,
  output logic                        evicted_o,
  output logic [cpr_pkg::PAGE_W-1:0]  evicted_page_o,
  output logic [FW-1:0]               slot_o,
  output logic [cpr_pkg::HIT_W-1:0]   hit_count_o
);
  import cpr_pkg::*;

  cpr_state_e       state_q, state_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [AW-1:0]    pg_q, pg_d;
  logic [AW-1:0]    vic_q, vic_d;
  logic [FW-1:0]    hand_q, hand_d;
  logic [CW-1:0]    alloc_q, alloc_d;
  logic [HIT_W-1:0] hits_q, hits_d;

  logic              done_q, done_d;
  logic              hit_q, hit_d;
  logic              ev_q, ev_d;
  logic [PAGE_W-1:0] evp_q, evp_d;
  logic [FW-1:0]     slot_q, slot_d;

  logic              clr_last;
  logic              has_free;
  logic [FW-1:0]     hand_wrap;
  logic [FW-1:0]     hand_next;
  logic [AW-1:0]     pg_in;

  assign clr_last  = (clr_q == AW'(PAGES - 1));
  assign has_free  = (alloc_q < ring_n_i);
  assign hand_wrap = (CW'(hand_q) >= ring_n_i) ? '0 : hand_q;
  assign hand_next = ((CW'(hand_q) + CW'(1)) == ring_n_i) ? '0 : hand_q + FW'(1);
  assign pg_in     = AW'(page_mod(page_i, PAGES));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (pt_rdata_i[PT_PRESENT] || has_free) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (pt_rdata_i[PT_REFD]) begin
          state_d = ST_FETCH;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // memory ports and datapath
  always_comb begin
    pt_we_o    = 1'b0;
    pt_waddr_o = pg_q;
    pt_wdata_o = '0;
    pt_raddr_o = pg_in;
    fm_we_o    = 1'b0;
    fm_waddr_o = hand_q;
    fm_wdata_o = pg_q;
    fm_raddr_o = hand_q;

    clr_d   = clr_q;
    pg_d    = pg_q;
    vic_d   = vic_q;
    hand_d  = hand_q;
    alloc_d = alloc_q;
    hits_d  = hits_q;
    done_d  = 1'b0;
    hit_d   = hit_q;
    ev_d    = ev_q;
    evp_d   = evp_q;
    slot_d  = slot_q;

    unique case (state_q)
      ST_CLEAR: begin
        pt_we_o    = 1'b1;
        pt_waddr_o = clr_q;
        clr_d      = clr_q + AW'(1);
      end
      ST_IDLE: begin
        pg_d = pg_in;
      end
      ST_LOOKUP: begin
        pt_we_o = 1'b1;
        if (pt_rdata_i[PT_PRESENT]) begin
          pt_wdata_o = 2'b11;
          hits_d     = (hits_q == '1) ? hits_q : hits_q + HIT_W'(1);
          done_d     = 1'b1;
          hit_d      = 1'b1;
          ev_d       = 1'b0;
          evp_d      = '0;
          slot_d     = '0;
        end else begin
          // new page goes resident with its bit clear, now or after the sweep
          pt_wdata_o = 2'b10;
          if (has_free) begin
            fm_we_o    = 1'b1;
            fm_waddr_o = alloc_q[FW-1:0];
            alloc_d    = alloc_q + CW'(1);
            done_d     = 1'b1;
            hit_d      = 1'b0;
            ev_d       = 1'b0;
            evp_d      = '0;
            slot_d     = alloc_q[FW-1:0];
          end else begin
            hand_d     = hand_wrap;
            fm_raddr_o = hand_wrap;
          end
        end
      end
      ST_FETCH: begin
        pt_raddr_o = fm_rdata_i;
        vic_d      = fm_rdata_i;
      end
      ST_CHECK: begin
        pt_we_o    = 1'b1;
        pt_waddr_o = vic_q;
        hand_d     = hand_next;
        fm_raddr_o = hand_next;
        if (pt_rdata_i[PT_REFD]) begin
          pt_wdata_o = {pt_rdata_i[PT_PRESENT], 1'b0};
        end else begin
          pt_wdata_o = 2'b00;
          fm_we_o    = 1'b1;
          fm_waddr_o = hand_q;
          done_d     = 1'b1;
          hit_d      = 1'b0;
          ev_d       = 1'b1;
          evp_d      = PAGE_W'(vic_q);
          slot_d     = hand_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      hand_q  <= '0;
      alloc_q <= '0;
      hits_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      hand_q  <= hand_d;
      alloc_q <= alloc_d;
      hits_q  <= hits_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pg_q   <= pg_d;
    vic_q  <= vic_d;
    hit_q  <= hit_d;
    ev_q   <= ev_d;
    evp_q  <= evp_d;
    slot_q <= slot_d;
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign hit_o          = hit_q;
  assign evicted_o      = ev_q;
  assign evicted_page_o = evp_q;
  assign slot_o         = slot_q;
  assign hit_count_o    = hits_q;

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;

  import cpr_pkg::PAGE_W;
  import cpr_pkg::HIT_W;

  localparam int NPAGES  = cpr_pkg::PAGES_DEF;
  localparam int NFRAMES = cpr_pkg::FRAMES_DEF;
  localparam int RING_W  = 9;
  localparam int SLOT_W  = 8;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int TAIL_CYCLES = 20;

  // one queued stimulus word: either a page reference or a ring size write
  typedef struct packed {
    logic              is_ring;
    logic [RING_W-1:0] ring_val;
    logic [PAGE_W-1:0] page;
  } stim_word_t;

  typedef struct packed {
    logic              hit;
    logic              evicted;
    logic [PAGE_W-1:0] evicted_page;
    logic [SLOT_W-1:0] slot;
    logic [HIT_W-1:0]  hit_count;
  } result_word_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              start       = 1'b0;
  logic [PAGE_W-1:0] page_i      = '0;
  logic              cfg_we_i    = 1'b0;
  logic [RING_W-1:0] cfg_wdata_i = '0;
  logic              busy;
  logic              done_o;
  logic              hit_o;
  logic              evicted_o;
  logic [PAGE_W-1:0] evicted_page_o;
  logic [SLOT_W-1:0] slot_o;
  logic [HIT_W-1:0]  hit_count_o;

  clock_page_replacement_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .page_i         (page_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .hit_o          (hit_o),
    .evicted_o      (evicted_o),
    .evicted_page_o (evicted_page_o),
    .slot_o         (slot_o),
    .hit_count_o    (hit_count_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the replacement state
  // ---------------------------------------------------------------------------
  bit                page_present [NPAGES];
  bit                page_refd    [NPAGES];
  logic [PAGE_W-1:0] frame_page   [NFRAMES];
  int unsigned       hand_pos;
  int unsigned       frames_filled;
  logic [HIT_W-1:0]  hits_total;
  logic [RING_W-1:0] ring_reg;

  stim_word_t   stim_q [$];
  result_word_t expected_q [$];
  int           fail_cnt;

  // 0 behaves as a single frame, anything past the frame count as the full ring
  function automatic int unsigned ring_span(input logic [RING_W-1:0] v);
    if (v == 0) return 1;
    if (v > NFRAMES) return NFRAMES;
    return v;
  endfunction

  function automatic result_word_t clock_replace(input logic [PAGE_W-1:0] pg);
    result_word_t r;
    int unsigned  n;
    int unsigned  laps;
    logic [PAGE_W-1:0] victim;
    r = '0;
    n = ring_span(ring_reg);
    if (page_present[pg]) begin
      page_refd[pg] = 1'b1;
      if (hits_total != '1) hits_total = hits_total + 1'b1;
      r.hit = 1'b1;
    end else if (frames_filled < n) begin
      r.slot = frames_filled[SLOT_W-1:0];
      frame_page[frames_filled] = pg;
      frames_filled = frames_filled + 1;
      page_present[pg] = 1'b1;
      page_refd[pg] = 1'b0;
    end else begin
      // ring shrunk under the hand: restart at frame 0
      if (hand_pos >= n) hand_pos = 0;
      laps = 0;
      // second chance sweep; one lap clears every bit passed
      while (laps <= n && page_refd[frame_page[hand_pos]]) begin
        page_refd[frame_page[hand_pos]] = 1'b0;
        hand_pos = (hand_pos + 1) % n;
        laps = laps + 1;
      end
      victim = frame_page[hand_pos];
      page_present[victim] = 1'b0;
      page_refd[victim] = 1'b0;
      r.evicted = 1'b1;
      r.evicted_page = victim;
      r.slot = hand_pos[SLOT_W-1:0];
      frame_page[hand_pos] = pg;
      page_present[pg] = 1'b1;
      page_refd[pg] = 1'b0;
      hand_pos = (hand_pos + 1) % n;
    end
    r.hit_count = hits_total;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of page words with random gaps; ring writes wait for quiet
  // ---------------------------------------------------------------------------
  int           burst_left;
  int           gap_left;
  int           quiet_cnt;
  logic         took;
  stim_word_t   drv_word;
  result_word_t drv_exp;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start       <= 1'b0;
      page_i      <= '0;
      cfg_we_i    <= 1'b0;
      cfg_wdata_i <= '0;
      burst_left  = 0;
      gap_left    = 0;
      quiet_cnt   = 0;
    end else begin
      took = start && !busy;
      if (took) begin
        drv_exp = clock_replace(page_i);
        expected_q.push_back(drv_exp);
      end
      if (expected_q.size() == 0 && !start && !cfg_we_i) quiet_cnt++;
      else quiet_cnt = 0;

      if (start && !took) begin
        // word still offered, keep it steady
      end else if (cfg_we_i) begin
        cfg_we_i <= 1'b0;
        start    <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (stim_q.size() == 0) begin
        start <= 1'b0;
      end else if (stim_q[0].is_ring) begin
        start <= 1'b0;
        // only once every result is home and the unit has settled
        if (quiet_cnt >= 4) begin
          drv_word = stim_q.pop_front();
          cfg_we_i    <= 1'b1;
          cfg_wdata_i <= drv_word.ring_val;
          ring_reg = drv_word.ring_val;
          quiet_cnt = 0;
        end
      end else begin
        drv_word = stim_q.pop_front();
        start  <= 1'b1;
        page_i <= drv_word.page;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          case ($urandom_range(0, 9))
            0, 1, 2: gap_left = 0;
            3, 4, 5: gap_left = 1;
            6, 7:    gap_left = $urandom_range(2, 4);
            default: gap_left = $urandom_range(5, 16);
          endcase
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: a result word is valid for the single cycle done_o is high
  // ---------------------------------------------------------------------------
  result_word_t mon_exp;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected");
        fail_cnt++;
      end else begin
        mon_exp = expected_q.pop_front();
        if (hit_o !== mon_exp.hit) begin
          $error("hit: expected %0d, got %0d", mon_exp.hit, hit_o);
          fail_cnt++;
        end
        if (evicted_o !== mon_exp.evicted) begin
          $error("evicted: expected %0d, got %0d", mon_exp.evicted, evicted_o);
          fail_cnt++;
        end
        if (evicted_page_o !== mon_exp.evicted_page) begin
          $error("evicted_page: expected %0d, got %0d",
                 mon_exp.evicted_page, evicted_page_o);
          fail_cnt++;
        end
        if (slot_o !== mon_exp.slot) begin
          $error("slot: expected %0d, got %0d", mon_exp.slot, slot_o);
          fail_cnt++;
        end
        if (hit_count_o !== mon_exp.hit_count) begin
          $error("hit_count: expected %0d, got %0d", mon_exp.hit_count, hit_count_o);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog
  int cycle_cnt = 0;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic void queue_page(input logic [PAGE_W-1:0] p);
    stim_word_t w;
    w = '0;
    w.page = p;
    stim_q.push_back(w);
  endfunction

  function automatic void queue_ring(input logic [RING_W-1:0] v);
    stim_word_t w;
    w = '0;
    w.is_ring = 1'b1;
    w.ring_val = v;
    stim_q.push_back(w);
  endfunction

  logic [RING_W-1:0] phase_ring [10];
  int unsigned       span;
  logic [PAGE_W-1:0] ws_base;
  logic [PAGE_W-1:0] last_page;
  logic [PAGE_W-1:0] pg;

  initial begin
    for (int i = 0; i < NPAGES; i++) begin
      page_present[i] = 1'b0;
      page_refd[i] = 1'b0;
    end
    for (int i = 0; i < NFRAMES; i++) frame_page[i] = '0;
    hand_pos = 0;
    frames_filled = 0;
    hits_total = '0;
    ring_reg = 9'd256;
    fail_cnt = 0;

    // directed: field extremes at the reset ring size
    queue_page(10'd0);
    queue_page(10'd1023);
    queue_page(10'd0);
    queue_page(10'd1023);
    queue_page(10'd512);
    // shrink below the fill level: second chance sweep, frame 2 left outside
    queue_ring(9'd2);
    queue_page(10'd5);
    queue_page(10'd512);
    queue_page(10'd6);
    queue_page(10'd5);
    // zero acts as a single frame
    queue_ring(9'd0);
    queue_page(10'd7);
    queue_page(10'd8);
    queue_page(10'd8);
    queue_page(10'd9);
    // above the frame count acts as the full ring; filling resumes
    queue_ring(9'd511);
    queue_page(10'd341);
    queue_page(10'd682);
    queue_page(10'd341);
    queue_page(10'd512);
    queue_ring(9'd3);
    queue_page(10'd100);
    queue_page(10'd101);

    // random phases, each under a ring size of its own
    phase_ring[0] = 9'd256;
    phase_ring[1] = 9'd1;
    phase_ring[2] = 9'd511;
    phase_ring[3] = 9'd0;
    phase_ring[4] = 9'd2;
    phase_ring[5] = 9'($urandom_range(5, 40));
    phase_ring[6] = 9'd300;
    phase_ring[7] = 9'($urandom_range(1, 256));
    phase_ring[8] = 9'd16;
    phase_ring[9] = 9'd4;
    last_page = '0;
    for (int ph = 0; ph < 10; ph++) begin
      queue_ring(phase_ring[ph]);
      span = ring_span(phase_ring[ph]);
      for (int k = 0; k < 200; k++) begin
        // working set a little larger than the ring, drifting now and then
        if (k % 50 == 0) ws_base = 10'($urandom_range(0, NPAGES - 1));
        case ($urandom_range(0, 19))
          0, 1, 2:    pg = last_page;
          3, 4, 5:    pg = 10'($urandom_range(0, NPAGES - 1));
          default:    pg = ws_base + 10'($urandom_range(0, span + span / 2 + 1));
        endcase
        queue_page(pg);
        last_page = pg;
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // all words taken and every result home
    @(negedge clk_i);
    while (stim_q.size() != 0 || start || cfg_we_i || expected_q.size() != 0)
      @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (fail_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
design/cpr_pkg.sv
design/cpr_ram.sv
design/cpr_ctrl.sv
design/clock_page_replacement_unit.sv
verif/tb.sv
